>>> rtl/qmet_pkg.sv
// Shared types, constants and the microcode store for the quartic map escape-time engine.
// Used by every module of the block; depends on nothing.
package qmet_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 24;
    localparam int ITER_WIDTH = 16;
    localparam int COLOR_W    = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int PC_W       = 6;

    localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // integer constant in fixed point, clipped to the positive limit
    function automatic logic [DATA_WIDTH-1:0] konst(input int unsigned k);
        logic [127:0] v;
        v = 128'(k) << FRAC_BITS;
        if (v > 128'(VMAX)) begin
            return VMAX;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    localparam logic [DATA_WIDTH-1:0] K_ONE     = konst(1);
    localparam logic [DATA_WIDTH-1:0] K_TWO     = konst(2);
    localparam logic [DATA_WIDTH-1:0] K_HUNDRED = konst(100);

    // register reset values
    localparam logic [DATA_WIDTH-1:0] RST_MULT_RE  = DATA_WIDTH'(-12370999);
    localparam logic [DATA_WIDTH-1:0] RST_MULT_IM  = DATA_WIDTH'(-11332842);
    localparam logic [DATA_WIDTH-1:0] RST_COEF_RE  = DATA_WIDTH'(16777216);
    localparam logic [DATA_WIDTH-1:0] RST_COEF_IM  = '0;
    localparam logic [ITER_WIDTH-1:0] RST_MAX_ITER = ITER_WIDTH'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT_RE  = 3'd0,
        CFG_MULT_IM  = 3'd1,
        CFG_COEF_RE  = 3'd2,
        CFG_COEF_IM  = 3'd3,
        CFG_MAX_ITER = 3'd4
    } t_cfg_idx;

    // datapath operands; codes below N_WR are writable scratch registers
    typedef enum logic [4:0] {
        REG_P_RE = 5'd0,
        REG_P_IM = 5'd1,
        REG_T_RE = 5'd2,
        REG_T_IM = 5'd3,
        REG_D_RE = 5'd4,
        REG_K_RE = 5'd5,
        REG_U_RE = 5'd6,
        REG_U_IM = 5'd7,
        REG_M0   = 5'd8,
        REG_M1   = 5'd9,
        REG_M2   = 5'd10,
        REG_M3   = 5'd11,
        REG_M4   = 5'd12,
        REG_M5   = 5'd13,
        REG_M6   = 5'd14,
        REG_A_RE = 5'd15,
        REG_A_IM = 5'd16,
        REG_B_RE = 5'd17,
        REG_B_IM = 5'd18,
        REG_ONE  = 5'd19,
        REG_TWO  = 5'd20
    } t_reg;

    localparam int N_WR  = 15;
    localparam int N_REG = 21;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_MUL  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_NORM = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        FL_NEXT = 2'd0,
        FL_TEST = 2'd1,
        FL_LOOP = 2'd2,
        FL_FIN  = 2'd3
    } t_flow;

    typedef struct packed {
        t_op              op;
        t_reg             a;
        t_reg             b;
        t_reg             dst;
        logic             tst;   // saturation belongs to the radius test
        logic             clr;   // clear saturation flags
        t_flow            flow;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic outside;
        logic ssat;
    } t_dp_status;

    typedef struct packed {
        logic                  done;
        logic                  escaped;
        logic [COLOR_W-1:0]    color;
    } t_result;

    typedef struct packed {
        logic                  valid;
        t_reg                  dst;
        logic                  tst;
        logic                  sat;
        logic [DATA_WIDTH-1:0] value;
    } t_mul_wb;

    localparam logic [PC_W-1:0] LOOP_ADDR = PC_W'(0);
    localparam logic [PC_W-1:0] FIN_ADDR  = PC_W'(34);

    function automatic t_ctrl cw(input t_op op, input t_reg a, input t_reg b, input t_reg dst,
                                 input logic tst, input logic clr, input t_flow flow);
        t_ctrl w;
        w.op     = op;
        w.a      = a;
        w.b      = b;
        w.dst    = dst;
        w.tst    = tst;
        w.clr    = clr;
        w.flow   = flow;
        w.target = FIN_ADDR;
        return w;
    endfunction

    // Microprogram. Products are readable once they have passed the multiplier pipeline
    // and been written back, sums in the step after issue; the schedule below honors both.
    function automatic t_ctrl rom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            // radius test, plus per-step constants d.re and a.re - 2
            6'd0:  w = cw(OP_MUL,  REG_P_RE, REG_P_RE, REG_M0,   1'b1, 1'b1, FL_NEXT);
            6'd1:  w = cw(OP_MUL,  REG_P_IM, REG_P_IM, REG_M1,   1'b1, 1'b0, FL_NEXT);
            6'd2:  w = cw(OP_SUB,  REG_P_RE, REG_ONE,  REG_D_RE, 1'b0, 1'b0, FL_NEXT);
            6'd3:  w = cw(OP_SUB,  REG_A_RE, REG_TWO,  REG_K_RE, 1'b0, 1'b0, FL_NEXT);
            6'd4:  w = cw(OP_NORM, REG_M0,   REG_M1,   REG_M0,   1'b0, 1'b0, FL_NEXT);
            6'd5:  w = cw(OP_NOP,  REG_M0,   REG_M0,   REG_M0,   1'b0, 1'b0, FL_TEST);
            // t = b*p + a - 2, and d*d started alongside
            6'd6:  w = cw(OP_MUL,  REG_B_RE, REG_P_RE, REG_M0,   1'b0, 1'b0, FL_NEXT);
            6'd7:  w = cw(OP_MUL,  REG_B_IM, REG_P_IM, REG_M1,   1'b0, 1'b0, FL_NEXT);
            6'd8:  w = cw(OP_MUL,  REG_B_RE, REG_P_IM, REG_M2,   1'b0, 1'b0, FL_NEXT);
            6'd9:  w = cw(OP_MUL,  REG_B_IM, REG_P_RE, REG_M3,   1'b0, 1'b0, FL_NEXT);
            6'd10: w = cw(OP_MUL,  REG_D_RE, REG_D_RE, REG_M4,   1'b0, 1'b0, FL_NEXT);
            6'd11: w = cw(OP_MUL,  REG_P_IM, REG_P_IM, REG_M5,   1'b0, 1'b0, FL_NEXT);
            6'd12: w = cw(OP_MUL,  REG_D_RE, REG_P_IM, REG_M6,   1'b0, 1'b0, FL_NEXT);
            6'd13: w = cw(OP_SUB,  REG_M0,   REG_M1,   REG_T_RE, 1'b0, 1'b0, FL_NEXT);
            6'd14: w = cw(OP_ADD,  REG_M2,   REG_M3,   REG_T_IM, 1'b0, 1'b0, FL_NEXT);
            6'd15: w = cw(OP_ADD,  REG_T_RE, REG_K_RE, REG_T_RE, 1'b0, 1'b0, FL_NEXT);
            6'd16: w = cw(OP_ADD,  REG_T_IM, REG_A_IM, REG_T_IM, 1'b0, 1'b0, FL_NEXT);
            // t = t*p - 1, with u = d*d assembled alongside
            6'd17: w = cw(OP_MUL,  REG_T_RE, REG_P_RE, REG_M0,   1'b0, 1'b0, FL_NEXT);
            6'd18: w = cw(OP_MUL,  REG_T_IM, REG_P_IM, REG_M1,   1'b0, 1'b0, FL_NEXT);
            6'd19: w = cw(OP_MUL,  REG_T_RE, REG_P_IM, REG_M2,   1'b0, 1'b0, FL_NEXT);
            6'd20: w = cw(OP_MUL,  REG_T_IM, REG_P_RE, REG_M3,   1'b0, 1'b0, FL_NEXT);
            6'd21: w = cw(OP_SUB,  REG_M4,   REG_M5,   REG_U_RE, 1'b0, 1'b0, FL_NEXT);
            6'd22: w = cw(OP_ADD,  REG_M6,   REG_M6,   REG_U_IM, 1'b0, 1'b0, FL_NEXT);
            6'd23: w = cw(OP_SUB,  REG_M0,   REG_M1,   REG_T_RE, 1'b0, 1'b0, FL_NEXT);
            6'd24: w = cw(OP_ADD,  REG_M2,   REG_M3,   REG_T_IM, 1'b0, 1'b0, FL_NEXT);
            6'd25: w = cw(OP_SUB,  REG_T_RE, REG_ONE,  REG_T_RE, 1'b0, 1'b0, FL_NEXT);
            // p' = (d*d)*t + 1
            6'd26: w = cw(OP_MUL,  REG_U_RE, REG_T_RE, REG_M0,   1'b0, 1'b0, FL_NEXT);
            6'd27: w = cw(OP_MUL,  REG_U_IM, REG_T_IM, REG_M1,   1'b0, 1'b0, FL_NEXT);
            6'd28: w = cw(OP_MUL,  REG_U_RE, REG_T_IM, REG_M2,   1'b0, 1'b0, FL_NEXT);
            6'd29: w = cw(OP_MUL,  REG_U_IM, REG_T_RE, REG_M3,   1'b0, 1'b0, FL_NEXT);
            6'd30: w = cw(OP_SUB,  REG_M0,   REG_M1,   REG_P_RE, 1'b0, 1'b0, FL_NEXT);
            6'd31: w = cw(OP_ADD,  REG_P_RE, REG_ONE,  REG_P_RE, 1'b0, 1'b0, FL_NEXT);
            6'd32: w = cw(OP_ADD,  REG_M2,   REG_M3,   REG_P_IM, 1'b0, 1'b0, FL_NEXT);
            6'd33: w = cw(OP_NOP,  REG_M0,   REG_M0,   REG_M0,   1'b0, 1'b0, FL_LOOP);
            default: w = cw(OP_NOP, REG_M0,  REG_M0,   REG_M0,   1'b0, 1'b0, FL_FIN);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/qmet_mul.sv
// Three-stage saturating fixed-point multiplier: magnitudes, product, truncate and clip.
// Depends on qmet_pkg.
module qmet_mul
    import qmet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_issue,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    input  t_reg                  i_dst,
    input  logic                  i_tst,
    output t_mul_wb               o_wb
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int RW = PW - FRAC_BITS;

    logic                  r_s1_valid, r_s2_valid;
    t_reg                  r_s1_dst, r_s2_dst;
    logic                  r_s1_tst, r_s2_tst, r_s1_neg, r_s2_neg;
    logic [DATA_WIDTH-1:0] r_mag_a, r_mag_b;
    logic [PW-1:0]         r_prod;

    logic [DATA_WIDTH-1:0] w_mag_a, w_mag_b;
    logic [RW-1:0]         w_r, w_lim;
    logic                  w_sat;

    assign w_mag_a = i_a[DATA_WIDTH-1] ? (~i_a) + DATA_WIDTH'(1) : i_a;
    assign w_mag_b = i_b[DATA_WIDTH-1] ? (~i_b) + DATA_WIDTH'(1) : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dst <= i_dst;
        r_s1_tst <= i_tst;
        r_s1_neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        r_mag_a  <= w_mag_a;
        r_mag_b  <= w_mag_b;
        r_s2_dst <= r_s1_dst;
        r_s2_tst <= r_s1_tst;
        r_s2_neg <= r_s1_neg;
        r_prod   <= PW'(r_mag_a) * PW'(r_mag_b);
    end

    // magnitude truncated toward zero; negative side may reach one past VMAX
    assign w_r   = r_prod[PW-1:FRAC_BITS];
    assign w_lim = r_s2_neg ? RW'(VMAX) + RW'(1) : RW'(VMAX);
    assign w_sat = w_r > w_lim;

    always_comb begin
        o_wb.valid = r_s2_valid;
        o_wb.dst   = r_s2_dst;
        o_wb.tst   = r_s2_tst;
        o_wb.sat   = w_sat;
        if (w_sat) begin
            o_wb.value = r_s2_neg ? VMIN : VMAX;
        end else if (r_s2_neg) begin
            o_wb.value = (~w_r[DATA_WIDTH-1:0]) + DATA_WIDTH'(1);
        end else begin
            o_wb.value = w_r[DATA_WIDTH-1:0];
        end
    end

endmodule

>>> rtl/qmet_dp.sv
// Datapath: scratch registers, saturating adder and the shared multiplier, driven by
// one control word per cycle. Depends on qmet_pkg and qmet_mul.
module qmet_dp
    import qmet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic                  i_load,
    input  logic [DATA_WIDTH-1:0] i_start_re,
    input  logic [DATA_WIDTH-1:0] i_start_im,
    input  logic [DATA_WIDTH-1:0] i_mult_re,
    input  logic [DATA_WIDTH-1:0] i_mult_im,
    input  logic [DATA_WIDTH-1:0] i_coef_re,
    input  logic [DATA_WIDTH-1:0] i_coef_im,
    output t_dp_status            o_status,
    output logic [DATA_WIDTH-1:0] o_p_re,
    output logic [DATA_WIDTH-1:0] o_p_im
);

    logic [DATA_WIDTH-1:0] r_rf [N_WR];
    logic                  r_ssat, r_tsat, r_outside;
    logic                  n_ssat, n_tsat;

    logic [DATA_WIDTH-1:0] w_src [N_REG];
    logic [DATA_WIDTH-1:0] w_a, w_b, w_alu;
    logic [DATA_WIDTH:0]   w_sum;
    logic                  w_ovf, w_alu_we, w_norm;
    t_mul_wb               w_wb;

    always_comb begin
        for (int i = 0; i < N_WR; i++) begin
            w_src[i] = r_rf[i];
        end
        w_src[REG_A_RE] = i_mult_re;
        w_src[REG_A_IM] = i_mult_im;
        w_src[REG_B_RE] = i_coef_re;
        w_src[REG_B_IM] = i_coef_im;
        w_src[REG_ONE]  = K_ONE;
        w_src[REG_TWO]  = K_TWO;
    end

    assign w_a = w_src[i_ctrl.a];
    assign w_b = w_src[i_ctrl.b];

    // saturating add/sub, one extra sign bit for overflow detect
    always_comb begin
        if (i_ctrl.op == OP_SUB) begin
            w_sum = {w_a[DATA_WIDTH-1], w_a} - {w_b[DATA_WIDTH-1], w_b};
        end else begin
            w_sum = {w_a[DATA_WIDTH-1], w_a} + {w_b[DATA_WIDTH-1], w_b};
        end
        w_ovf = w_sum[DATA_WIDTH] ^ w_sum[DATA_WIDTH-1];
        if (w_ovf) begin
            w_alu = w_sum[DATA_WIDTH] ? VMIN : VMAX;
        end else begin
            w_alu = w_sum[DATA_WIDTH-1:0];
        end
    end

    assign w_alu_we = (i_ctrl.op == OP_ADD) || (i_ctrl.op == OP_SUB);
    assign w_norm   = (i_ctrl.op == OP_NORM);

    qmet_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (i_ctrl.op == OP_MUL),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_dst   (i_ctrl.dst),
        .i_tst   (i_ctrl.tst),
        .o_wb    (w_wb)
    );

    // microcode never targets one register from both ports in a cycle
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_WR; i++) begin
            if (i_load && t_reg'(i) == REG_P_RE) begin
                r_rf[i] <= i_start_re;
            end
            if (i_load && t_reg'(i) == REG_P_IM) begin
                r_rf[i] <= i_start_im;
            end
            if (w_alu_we && i_ctrl.dst == t_reg'(i)) begin
                r_rf[i] <= w_alu;
            end
            if (w_wb.valid && w_wb.dst == t_reg'(i)) begin
                r_rf[i] <= w_wb.value;
            end
        end
    end

    always_comb begin
        n_ssat = (i_ctrl.clr ? 1'b0 : r_ssat) | (w_alu_we & w_ovf)
               | (w_wb.valid & ~w_wb.tst & w_wb.sat);
        n_tsat = (i_ctrl.clr ? 1'b0 : r_tsat) | (w_wb.valid & w_wb.tst & w_wb.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssat    <= 1'b0;
            r_tsat    <= 1'b0;
            r_outside <= 1'b0;
        end else begin
            r_ssat <= n_ssat;
            r_tsat <= n_tsat;
            if (w_norm) begin
                r_outside <= w_ovf | r_tsat | ($signed(w_alu) >= $signed(K_HUNDRED));
            end
        end
    end

    assign o_status.outside = r_outside;
    assign o_status.ssat    = r_ssat;
    assign o_p_re           = w_src[REG_P_RE];
    assign o_p_im           = w_src[REG_P_IM];

endmodule

>>> rtl/qmet_seq.sv
// Microcode sequencer: step counter, iteration count, branch logic and result flags.
// Depends on qmet_pkg (control word layout and program store).
module qmet_seq
    import qmet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_opcode,
    input  logic [ITER_WIDTH-1:0] i_max_iter,
    input  logic                  i_out_free,
    input  t_dp_status            i_status,
    output logic                  o_in_ready,
    output logic                  o_load,
    output t_ctrl                 o_ctrl,
    output t_result               o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [ITER_WIDTH-1:0] r_cnt, n_cnt;
    logic                  r_op, n_op;
    logic                  w_done, w_escaped;
    t_ctrl                 w_word;

    assign w_word = rom(r_pc);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        n_op    = r_op;
        w_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_pc    = LOOP_ADDR;
                    n_cnt   = '0;
                    n_op    = i_opcode;
                end
            end
            ST_RUN: begin
                unique case (w_word.flow)
                    FL_NEXT: n_pc = r_pc + 1'b1;
                    FL_TEST: begin
                        if (!r_op && (r_cnt >= i_max_iter || i_status.outside)) begin
                            n_pc = w_word.target;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    FL_LOOP: begin
                        n_cnt = r_cnt + 1'b1;
                        if (r_op || i_status.ssat) begin
                            n_pc = w_word.target;
                        end else begin
                            n_pc = LOOP_ADDR;
                        end
                    end
                    FL_FIN: begin
                        if (i_out_free) begin
                            w_done  = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    default: n_pc = r_pc;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= LOOP_ADDR;
            r_cnt   <= '0;
            r_op    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
        end
    end

    always_comb begin
        o_ctrl = w_word;
        if (r_state != ST_RUN) begin
            o_ctrl.op  = OP_NOP;
            o_ctrl.clr = 1'b0;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_load     = (r_state == ST_IDLE) && i_in_valid;

    // escaped iff stopped before the limit; color = 6 * count
    assign w_escaped   = !r_op && (r_cnt < i_max_iter);
    assign o_res.done    = w_done;
    assign o_res.escaped = w_escaped;
    assign o_res.color   = w_escaped
                         ? COLOR_W'({r_cnt, 2'b00}) + COLOR_W'({r_cnt, 1'b0})
                         : '0;

endmodule

>>> rtl/quartic_map_escape_time_top.sv
// Top level of the quartic map escape-time engine: configuration registers, sequencer,
// datapath and the result register. Depends on qmet_pkg, qmet_seq and qmet_dp.
//
// Iterates p -> (p-1)^2 ((b p + a - 2) p - 1) + 1 on signed Q8.24 complex values with
// saturating arithmetic. Opcode 0 runs escape-time: before each step |p|^2 is checked
// against 100 (a saturated norm counts as outside), and a step that saturates anywhere
// ends the orbit as escaped unless the count has just reached max_iterations. The beat
// returns escaped and color_index = 6 * steps (both 0 when the limit is reached or
// max_iterations is 0). Opcode 1 takes one step and returns next_re/next_im; the unused
// fields of each opcode read 0. A 35-entry microprogram drives one three-stage pipelined
// 32x32 multiplier and one saturating adder; each map step runs 15 products and 14 sums,
// plus the radius test. The next input beat is accepted once the result sits in the
// output register, even if it has not been taken. Configuration writes take effect at
// once and are meant for idle periods only; writes to register indexes above four are
// dropped.
module quartic_map_escape_time_top
    import qmet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    // input beat
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic [DATA_WIDTH-1:0] i_start_re,
    input  logic [DATA_WIDTH-1:0] i_start_im,
    // result beat
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_escaped,
    output logic [COLOR_W-1:0]    o_color_index,
    output logic [DATA_WIDTH-1:0] o_next_re,
    output logic [DATA_WIDTH-1:0] o_next_im
);

    logic [DATA_WIDTH-1:0] r_mult_re, r_mult_im, r_coef_re, r_coef_im;
    logic [ITER_WIDTH-1:0] r_max_iter;

    logic                  r_out_valid;
    logic                  r_escaped;
    logic [COLOR_W-1:0]    r_color;
    logic [DATA_WIDTH-1:0] r_next_re, r_next_im;

    logic                  w_out_free, w_load;
    t_ctrl                 w_ctrl;
    t_result               w_res;
    t_dp_status            w_status;
    logic [DATA_WIDTH-1:0] w_p_re, w_p_im;
    logic                  r_op_is_step;

    // configuration register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult_re  <= RST_MULT_RE;
            r_mult_im  <= RST_MULT_IM;
            r_coef_re  <= RST_COEF_RE;
            r_coef_im  <= RST_COEF_IM;
            r_max_iter <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MULT_RE:  r_mult_re  <= i_cfg_data;
                CFG_MULT_IM:  r_mult_im  <= i_cfg_data;
                CFG_COEF_RE:  r_coef_re  <= i_cfg_data;
                CFG_COEF_IM:  r_coef_im  <= i_cfg_data;
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // output register frees up in the same cycle its beat is taken
    assign w_out_free = !r_out_valid || i_out_ready;

    qmet_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_max_iter (r_max_iter),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_load     (w_load),
        .o_ctrl     (w_ctrl),
        .o_res      (w_res)
    );

    qmet_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_load     (w_load),
        .i_start_re (i_start_re),
        .i_start_im (i_start_im),
        .i_mult_re  (r_mult_re),
        .i_mult_im  (r_mult_im),
        .i_coef_re  (r_coef_re),
        .i_coef_im  (r_coef_im),
        .o_status   (w_status),
        .o_p_re     (w_p_re),
        .o_p_im     (w_p_im)
    );

    // opcode of the item in flight, for steering the point onto the result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op_is_step <= i_opcode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_escaped <= w_res.escaped;
            r_color   <= w_res.color;
            r_next_re <= r_op_is_step ? w_p_re : '0;
            r_next_im <= r_op_is_step ? w_p_im : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_escaped     = r_escaped;
    assign o_color_index = r_color;
    assign o_next_re     = r_next_re;
    assign o_next_im     = r_next_im;

endmodule
